// ===== rtl/core/fwr_pkg.sv =====
// fwr_pkg: shared types, codes and sizes for the fifo with remove-by-value
// no dependencies; imported by fwr_cell and fifo_with_remove_by_value_top
`timescale 1ns / 1ps

package fwr_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int VAL_W       = 32;

    // action codes
    localparam logic [1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [1:0] ACT_DEQUEUE = 2'd1;
    localparam logic [1:0] ACT_REMOVE  = 2'd2;
    localparam logic [1:0] ACT_PEEK    = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic        [1:0]       action;
        logic signed [VAL_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] data;
        logic        [1:0]       status;
        logic        [CNT_W-1:0] count;
        logic                    is_empty;
    } t_res;

    // control shared by every cell of the chain
    typedef struct packed {
        logic                    go;
        logic                    cmp_en;
        logic signed [VAL_W-1:0] key;
    } t_cell_ctl;

endpackage

// ===== rtl/core/fifo_with_remove_by_value_top.sv =====
// fifo_with_remove_by_value_top: bounded fifo with remove-by-value, chain of fwr_cell
// the result is registered at each input transfer; throughput one action per cycle while i_ready drains the output
// every action (enqueue, dequeue, remove, peek) completes in the cycle it is accepted
// reset: synchronous active-low i_rst_n clears the count and the result valid; slots are not cleared
// depends on fwr_pkg and fwr_cell
`timescale 1ns / 1ps

module fifo_with_remove_by_value_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  fwr_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output fwr_pkg::t_res  o_res
);
    import fwr_pkg::*;

    // state: entry count and the registered result
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid;
    t_res             r_res, n_res;

    // chain wiring
    logic                    w_hit  [QUEUE_DEPTH+1];
    logic signed [VAL_W-1:0] w_val  [QUEUE_DEPTH];
    logic                    w_live [QUEUE_DEPTH];
    logic                    w_load [QUEUE_DEPTH];
    t_cell_ctl               w_ctl;

    logic w_fire;
    logic w_empty;
    logic w_full;
    logic w_found;

    // a new transfer is taken whenever the result register is free or being drained
    assign o_ready = !r_out_valid || i_ready;
    assign w_fire  = i_valid && o_ready;
    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == CNT_W'(QUEUE_DEPTH));

    // control broadcast to all cells
    assign w_ctl.go     = w_fire;
    assign w_ctl.cmp_en = (i_item.action == ACT_REMOVE);
    assign w_ctl.key    = i_item.value;

    // dequeue shifts the whole chain; remove starts the shift at the first match
    assign w_hit[0] = (i_item.action == ACT_DEQUEUE) && !w_empty;
    assign w_found  = w_hit[QUEUE_DEPTH];

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            // slot is occupied when its position is below the count
            assign w_live[g] = (CNT_W'(g) < r_count);
            // enqueue writes the first free slot
            assign w_load[g] = (i_item.action == ACT_ENQUEUE) && (r_count == CNT_W'(g));

            fwr_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_live     (w_live[g]),
                .i_load     (w_load[g]),
                .i_load_val (i_item.value),
                .i_next_val (w_val[(g + 1 < QUEUE_DEPTH) ? g + 1 : g]),
                .i_hit      (w_hit[g]),
                .o_hit      (w_hit[g+1]),
                .o_val      (w_val[g])
            );
        end
    endgenerate

    // next count and result for the current action
    always_comb begin
        n_count     = r_count;
        n_res       = '0;
        unique case (i_item.action)
            ACT_ENQUEUE: begin
                if (w_full) begin
                    n_res.status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_DEQUEUE: begin
                if (w_empty) begin
                    n_res.status = ST_EMPTY;
                end else begin
                    n_res.data = w_val[0];
                    n_count    = r_count - CNT_W'(1);
                end
            end
            ACT_REMOVE: begin
                if (w_found) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_res.status = ST_NOT_FOUND;
                end
            end
            ACT_PEEK: begin
                if (w_empty) begin
                    n_res.status = ST_EMPTY;
                end else begin
                    n_res.data = w_val[0];
                end
            end
            default: begin
                n_res.status = ST_OK;
            end
        endcase
        n_res.count    = n_count;
        n_res.is_empty = (n_count == '0);
    end

    // count and output valid are control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded on each input transfer
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

`ifndef SYNTH
    // count never runs past the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above depth");

    // a successful enqueue adds exactly one entry
    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (i_item.action == ACT_ENQUEUE) && !w_full)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("enqueue did not advance count");

    // a dequeue returns the old head and the next slot moves to the head
    a_deq_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (i_item.action == ACT_DEQUEUE) && !w_empty && (r_count > CNT_W'(1)))
        |=> ((r_res.data == $past(w_val[0])) && (w_val[0] == $past(w_val[1]))))
        else $error("dequeue head mismatch");

    // empty flag agrees with reported count
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_res.is_empty == (r_res.count == '0)))
        else $error("empty flag disagrees with count");
`endif

endmodule

// ===== rtl/core/fwr_cell.sv =====
// fwr_cell: one storage slot of the queue chain with its own compare
// depends on fwr_pkg
`timescale 1ns / 1ps

module fwr_cell (
    input  logic                          i_clk,
    input  fwr_pkg::t_cell_ctl            i_ctl,
    input  logic                          i_live,
    input  logic                          i_load,
    input  logic signed [fwr_pkg::VAL_W-1:0] i_load_val,
    input  logic signed [fwr_pkg::VAL_W-1:0] i_next_val,
    input  logic                          i_hit,
    output logic                          o_hit,
    output logic signed [fwr_pkg::VAL_W-1:0] o_val
);
    import fwr_pkg::*;

    logic signed [VAL_W-1:0] r_val;
    logic                    w_match;

    // first match or anything after it closes up toward the head
    assign w_match = i_ctl.cmp_en && i_live && (r_val == i_ctl.key);
    assign o_hit   = i_hit || w_match;
    assign o_val   = r_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.go) begin
            if (i_load) begin
                r_val <= i_load_val;
            end else if (o_hit) begin
                r_val <= i_next_val;
            end
        end
    end

endmodule
